/* sv/piecewise_affine_mesh_warp_defines.svh */
// assertion macros shared by the mesh warp rtl
`ifndef PIECEWISE_AFFINE_MESH_WARP_DEFINES_SVH
`define PIECEWISE_AFFINE_MESH_WARP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PAMW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PAMW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pamw_pkg.sv */
// shared types, constants and rounding function of the mesh warp
package pamw_pkg;

    localparam int MAX_TRI_DEF = 64;
    localparam int COORD_W     = 32;
    localparam int TC_W        = 7;
    localparam int SLOT_W      = 6;
    localparam int CORNER_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int LANES       = 6;
    localparam int OP_W        = 33;
    localparam int PROD_W      = 66;
    localparam int WIDE_W      = 67;
    localparam int MAG_W       = 66;
    localparam int Q_W         = 18;
    localparam int DIV_W       = MAG_W + Q_W;
    localparam int STEP_W      = 5;
    localparam int ROUND_BITS  = 16;
    localparam int ROUND_HALF  = 32768;
    localparam int WEIGHT_W    = 19;
    localparam int WEIGHT_ONE  = 65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAT_XX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_XY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_YX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_YY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TCOUNT  = 3'd6;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    // corner codes
    localparam logic [CORNER_W-1:0] CORNER_0 = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_2 = 2'd2;

    typedef enum logic [1:0] {
        ROT_HOLD = 2'd0,
        ROT_ALL  = 2'd1,
        ROT_TAIL = 2'd2
    } rot_mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vtx_t;

    typedef struct packed {
        vtx_t [2:0] src;
        vtx_t [2:0] dst;
    } tri_t;

    // corner write broadcast to all cells
    typedef struct packed {
        logic                wr_en;
        logic [SLOT_W-1:0]   slot;
        logic [CORNER_W-1:0] corner;
        vtx_t                src;
        vtx_t                dst;
    } load_t;

    // drop 16 fraction bits, round half up, saturate to 32 bits
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0]            t;
        logic signed [WIDE_W-ROUND_BITS-1:0] r;
        logic signed [COORD_W-1:0]           res;
        t = x + WIDE_W'(ROUND_HALF);
        r = t[WIDE_W-1:ROUND_BITS];
        if (r[WIDE_W-ROUND_BITS-1] && !(&r[WIDE_W-ROUND_BITS-1:COORD_W-1])) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else if (!r[WIDE_W-ROUND_BITS-1] && (|r[WIDE_W-ROUND_BITS-1:COORD_W-1])) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            res = r[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

/* sv/pamw_cell.sv */
// one triangle cell of the rotating mesh chain
module pamw_cell
    import pamw_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic             aclk,
    input  load_t            ld,
    input  rot_mode_t        mode,
    input  logic [CNT_W-1:0] n,
    input  tri_t             next_in,
    input  tri_t             wrap_in,
    output tri_t             tri_q
);

    tri_t tri_reg, tri_next;
    logic in_range, is_last;

    assign in_range = 32'(IDX) < 32'(n);
    assign is_last  = 32'(IDX + 1) == 32'(n);

    // rotation among the slots in use, or a corner write
    always_comb begin
        tri_next = tri_reg;
        case (mode)
            ROT_ALL: begin
                if (in_range) begin
                    tri_next = is_last ? wrap_in : next_in;
                end
            end
            ROT_TAIL: begin
                if (in_range && IDX != 0) begin
                    tri_next = is_last ? wrap_in : next_in;
                end
            end
            default: begin
                if (ld.wr_en && 32'(ld.slot) == 32'(IDX) &&
                    (ld.corner inside {[CORNER_0:CORNER_2]})) begin
                    tri_next.src[ld.corner] = ld.src;
                    tri_next.dst[ld.corner] = ld.dst;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        tri_reg <= tri_next;
    end

    assign tri_q = tri_reg;

endmodule

/* sv/pamw_div.sv */
// restoring divider giving round(n / d) with 16 fraction bits
module pamw_div
    import pamw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] numer,
    input  logic [MAG_W-1:0] denom,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);

    logic [DIV_W-1:0]  rem_reg, rem_next, dv_reg, dv_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              load_reg, load_next, run_reg, run_next, done_reg, done_next;
    logic [DIV_W:0]    diff;

    assign diff = {1'b0, rem_reg} - {1'b0, dv_reg};

    // load, scale (n*2^17 + d over 2d), then one quotient bit a cycle
    always_comb begin
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        step_next = step_reg;
        load_next = 1'b0;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = DIV_W'(numer);
            dv_next   = DIV_W'(denom);
            load_next = 1'b1;
            run_next  = 1'b0;
        end else if (load_reg) begin
            rem_next  = (rem_reg << (Q_W - 1)) + dv_reg;
            dv_next   = dv_reg << Q_W;
            q_next    = '0;
            step_next = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
            end
            q_next  = {q_reg[Q_W-2:0], ~diff[DIV_W]};
            dv_next = dv_reg >> 1;
            if (step_reg == STEP_LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            load_reg <= load_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* sv/piecewise_affine_mesh_warp.sv */
// top level: affine map, rotating triangle chain search, barycentric warp
// load beat: taken back to back while idle, no result beat; point beats run one at a time
// point beat: a miss gives its result beat after the last probe; a hit waits for the divide
//   and for the tail rotation to finish before its result beat
// each probe steps through DIFF, MUL, SUB and TEST on the single barycentric unit at the chain head
// reset clears control and configuration; triangle cells hold no reset value
module piecewise_affine_mesh_warp
    import pamw_pkg::*;
#(
    parameter int MAX_TRIANGLES = MAX_TRI_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [SLOT_W-1:0]            s_slot,
    input  logic [CORNER_W-1:0]          s_corner,
    input  logic signed [COORD_W-1:0]    s_point_x,
    input  logic signed [COORD_W-1:0]    s_point_y,
    input  logic signed [COORD_W-1:0]    s_dest_x,
    input  logic signed [COORD_W-1:0]    s_dest_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_W-1:0]    m_out_x,
    output logic signed [COORD_W-1:0]    m_out_y,
    output logic                         m_found,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    `include "piecewise_affine_mesh_warp_defines.svh"

    localparam int CNT_W    = $clog2(MAX_TRIANGLES + 1);
    localparam int TAIL_IDX = (MAX_TRIANGLES > 1) ? 1 : 0;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_AFF_MUL = 12'b0000_0000_0010,
        ST_AFF_SUM = 12'b0000_0000_0100,
        ST_DIFF    = 12'b0000_0000_1000,
        ST_MUL     = 12'b0000_0001_0000,
        ST_SUB     = 12'b0000_0010_0000,
        ST_TEST    = 12'b0000_0100_0000,
        ST_DIV     = 12'b0000_1000_0000,
        ST_WGT     = 12'b0001_0000_0000,
        ST_OUT_MUL = 12'b0010_0000_0000,
        ST_OUT_SUM = 12'b0100_0000_0000,
        ST_FINISH  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [COORD_W-1:0] mat_xx_reg, mat_xy_reg, mat_yx_reg, mat_yy_reg;
    logic signed [COORD_W-1:0] shift_x_reg, shift_y_reg;
    logic [TC_W-1:0]           tcount_reg;

    logic [CNT_W-1:0] n_reg, n_next, probe_cnt_reg, probe_cnt_next;
    logic [CNT_W-1:0] rot_left_reg, rot_left_next;

    logic signed [OP_W-1:0]   op_a_reg [LANES], op_a_next [LANES];
    logic signed [OP_W-1:0]   op_b_reg [LANES], op_b_next [LANES];
    logic signed [PROD_W-1:0] prod_reg [LANES];

    logic signed [WIDE_W-1:0]  d_reg, d_next, vn_reg, vn_next, wn_reg, wn_next;
    logic signed [COORD_W-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                      res_found_reg, res_found_next;
    logic signed [COORD_W-1:0] m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic                      m_found_reg, m_found_next, m_valid_reg, m_valid_next;

    logic       in_fire;
    load_t      ld;
    rot_mode_t  rot_mode;
    tri_t       chain [MAX_TRIANGLES+1];
    tri_t       head, wrap;

    logic signed [WIDE_W-1:0]  aff_x, aff_y, warp_x, warp_y;
    logic signed [WIDE_W:0]    sum_vw, d_ext;
    logic                      d_neg, hit;
    logic [MAG_W-1:0]          d_mag, vn_mag, wn_mag;
    logic                      div_start, done_v, done_w, div_done;
    logic [Q_W-1:0]            q_v, q_w;
    logic signed [WEIGHT_W-1:0] wt_u, wt_v, wt_w;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign head    = chain[0];

    // corner write broadcast
    always_comb begin
        ld.wr_en  = in_fire && (s_func == FUNC_LOAD);
        ld.slot   = s_slot;
        ld.corner = s_corner;
        ld.src.x  = s_point_x;
        ld.src.y  = s_point_y;
        ld.dst.x  = s_dest_x;
        ld.dst.y  = s_dest_y;
    end

    // triangle chain, rotating toward cell 0
    assign wrap = (rot_mode == ROT_ALL) ? chain[0] : chain[TAIL_IDX];
    assign chain[MAX_TRIANGLES] = wrap;

    for (genvar k = 0; k < MAX_TRIANGLES; k++) begin : g_cell
        pamw_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .ld      (ld),
            .mode    (rot_mode),
            .n       (n_reg),
            .next_in (chain[k+1]),
            .wrap_in (wrap),
            .tri_q   (chain[k])
        );
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_xx_reg  <= COORD_W'(WEIGHT_ONE);
            mat_xy_reg  <= '0;
            mat_yx_reg  <= '0;
            mat_yy_reg  <= COORD_W'(WEIGHT_ONE);
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            tcount_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAT_XX:  mat_xx_reg  <= cfg_data;
                REG_MAT_XY:  mat_xy_reg  <= cfg_data;
                REG_MAT_YX:  mat_yx_reg  <= cfg_data;
                REG_MAT_YY:  mat_yy_reg  <= cfg_data;
                REG_SHIFT_X: shift_x_reg <= cfg_data;
                REG_SHIFT_Y: shift_y_reg <= cfg_data;
                REG_TCOUNT:  tcount_reg  <= cfg_data[TC_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath sums and the containment test
    always_comb begin
        aff_x  = WIDE_W'(prod_reg[0]) + WIDE_W'(prod_reg[1]) +
                 (WIDE_W'(shift_x_reg) <<< ROUND_BITS);
        aff_y  = WIDE_W'(prod_reg[2]) + WIDE_W'(prod_reg[3]) +
                 (WIDE_W'(shift_y_reg) <<< ROUND_BITS);
        warp_x = WIDE_W'(prod_reg[0]) + WIDE_W'(prod_reg[1]) + WIDE_W'(prod_reg[2]);
        warp_y = WIDE_W'(prod_reg[3]) + WIDE_W'(prod_reg[4]) + WIDE_W'(prod_reg[5]);
        sum_vw = (WIDE_W+1)'(vn_reg) + (WIDE_W+1)'(wn_reg);
        d_ext  = (WIDE_W+1)'(d_reg);
        d_neg  = d_reg[WIDE_W-1];
        if (d_reg == '0) begin
            hit = 1'b0;
        end else if (!d_neg) begin
            hit = !vn_reg[WIDE_W-1] && !wn_reg[WIDE_W-1] && (sum_vw <= d_ext);
        end else begin
            hit = (vn_reg[WIDE_W-1] || vn_reg == '0) && (wn_reg[WIDE_W-1] || wn_reg == '0) &&
                  (sum_vw >= d_ext);
        end
        d_mag  = MAG_W'(d_neg ? -d_reg : d_reg);
        vn_mag = MAG_W'(d_neg ? -vn_reg : vn_reg);
        wn_mag = MAG_W'(d_neg ? -wn_reg : wn_reg);
        wt_v   = WEIGHT_W'(q_v);
        wt_w   = WEIGHT_W'(q_w);
        wt_u   = WEIGHT_W'(WEIGHT_ONE) - wt_v - wt_w;
    end

    assign div_start = (state_reg == ST_TEST) && hit;
    assign div_done  = done_v && done_w;

    pamw_div u_div_v (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (vn_mag),
        .denom   (d_mag),
        .done    (done_v),
        .quot    (q_v)
    );

    pamw_div u_div_w (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (wn_mag),
        .denom   (d_mag),
        .done    (done_w),
        .quot    (q_w)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        probe_cnt_next = probe_cnt_reg;
        rot_left_next  = rot_left_reg;
        rot_mode       = ROT_HOLD;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        d_next         = d_reg;
        vn_next        = vn_reg;
        wn_next        = wn_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_found_next = res_found_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_found_next   = m_found_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        // tail shift after a hit, runs beside the weight work
        if (rot_left_reg != '0) begin
            rot_mode      = ROT_TAIL;
            rot_left_next = rot_left_reg - CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_func == FUNC_POINT) begin
                    n_next = (32'(tcount_reg) > 32'(MAX_TRIANGLES)) ?
                             CNT_W'(MAX_TRIANGLES) : CNT_W'(tcount_reg);
                    probe_cnt_next = '0;
                    op_a_next[0] = OP_W'(s_point_x);
                    op_b_next[0] = OP_W'(mat_xx_reg);
                    op_a_next[1] = OP_W'(s_point_y);
                    op_b_next[1] = OP_W'(mat_xy_reg);
                    op_a_next[2] = OP_W'(s_point_x);
                    op_b_next[2] = OP_W'(mat_yx_reg);
                    op_a_next[3] = OP_W'(s_point_y);
                    op_b_next[3] = OP_W'(mat_yy_reg);
                    state_next = ST_AFF_MUL;
                end
            end
            ST_AFF_MUL: begin
                state_next = ST_AFF_SUM;
            end
            ST_AFF_SUM: begin
                res_x_next     = round_sat(aff_x);
                res_y_next     = round_sat(aff_y);
                res_found_next = 1'b0;
                state_next     = (n_reg == '0) ? ST_FINISH : ST_DIFF;
            end
            // edge vectors of the head triangle
            ST_DIFF: begin
                op_a_next[0] = OP_W'(head.src[1].x) - OP_W'(head.src[0].x);
                op_b_next[0] = OP_W'(head.src[2].y) - OP_W'(head.src[0].y);
                op_a_next[1] = OP_W'(head.src[1].y) - OP_W'(head.src[0].y);
                op_b_next[1] = OP_W'(head.src[2].x) - OP_W'(head.src[0].x);
                op_a_next[2] = OP_W'(res_x_reg) - OP_W'(head.src[0].x);
                op_b_next[2] = op_b_next[0];
                op_a_next[3] = OP_W'(res_y_reg) - OP_W'(head.src[0].y);
                op_b_next[3] = op_b_next[1];
                op_a_next[4] = op_a_next[0];
                op_b_next[4] = op_a_next[3];
                op_a_next[5] = op_a_next[1];
                op_b_next[5] = op_a_next[2];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                d_next  = WIDE_W'(prod_reg[0]) - WIDE_W'(prod_reg[1]);
                vn_next = WIDE_W'(prod_reg[2]) - WIDE_W'(prod_reg[3]);
                wn_next = WIDE_W'(prod_reg[4]) - WIDE_W'(prod_reg[5]);
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (hit) begin
                    rot_left_next = n_reg - CNT_W'(1) - probe_cnt_reg;
                    state_next    = ST_DIV;
                end else begin
                    rot_mode = ROT_ALL;
                    if (probe_cnt_reg == n_reg - CNT_W'(1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        probe_cnt_next = probe_cnt_reg + CNT_W'(1);
                        state_next     = ST_DIFF;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_WGT;
                end
            end
            // weights times destination corners
            ST_WGT: begin
                op_a_next[0] = OP_W'(wt_u);
                op_b_next[0] = OP_W'(head.dst[0].x);
                op_a_next[1] = OP_W'(wt_v);
                op_b_next[1] = OP_W'(head.dst[1].x);
                op_a_next[2] = OP_W'(wt_w);
                op_b_next[2] = OP_W'(head.dst[2].x);
                op_a_next[3] = OP_W'(wt_u);
                op_b_next[3] = OP_W'(head.dst[0].y);
                op_a_next[4] = OP_W'(wt_v);
                op_b_next[4] = OP_W'(head.dst[1].y);
                op_a_next[5] = OP_W'(wt_w);
                op_b_next[5] = OP_W'(head.dst[2].y);
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL: begin
                state_next = ST_OUT_SUM;
            end
            ST_OUT_SUM: begin
                res_x_next     = round_sat(warp_x);
                res_y_next     = round_sat(warp_y);
                res_found_next = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                if (rot_left_reg == '0 && (!m_valid_reg || m_ready)) begin
                    m_x_next     = res_x_reg;
                    m_y_next     = res_y_reg;
                    m_found_next = res_found_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rot_left_reg  <= '0;
            probe_cnt_reg <= '0;
            n_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rot_left_reg  <= rot_left_next;
            probe_cnt_reg <= probe_cnt_next;
            n_reg         <= n_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // datapath registers, shared multiplier lanes
    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            op_a_reg[i] <= op_a_next[i];
            op_b_reg[i] <= op_b_next[i];
            prod_reg[i] <= PROD_W'(op_a_reg[i]) * PROD_W'(op_b_reg[i]);
        end
        d_reg         <= d_next;
        vn_reg        <= vn_next;
        wn_reg        <= wn_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_found_reg <= res_found_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_found_reg   <= m_found_next;
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = m_x_reg;
    assign m_out_y = m_y_reg;
    assign m_found = m_found_reg;

    // chain must be back in slot order before the next beat
    `PAMW_ASSERT_NOW(a_idle_no_rot, (state_reg == ST_IDLE), (rot_left_reg == '0), "rotation pending while idle")
    // probe index stays inside the slots in use
    `PAMW_ASSERT_NOW(a_probe_range, (state_reg == ST_DIFF), (probe_cnt_reg < n_reg), "probe past slot count")
    // tail shift never longer than the slots in use
    `PAMW_ASSERT_NOW(a_tail_range, (rot_left_reg != '0), (rot_left_reg < n_reg), "tail shift too long")
    // finishing a point leaves a result beat on the output
    `PAMW_ASSERT_NEXT(a_finish_out, (state_reg == ST_FINISH) && (state_next == ST_IDLE), m_valid, "result beat lost")

endmodule

/* dv/piecewise_affine_mesh_warp_test.sv */
// self-checking testbench for the piecewise affine mesh warp top level
module piecewise_affine_mesh_warp_test;
    import pamw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [95:0] wide_t;

    typedef struct {
        logic                       func;
        logic [SLOT_W-1:0]          slot;
        logic [CORNER_W-1:0]        corner;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  dx;
        logic signed [COORD_W-1:0]  dy;
    } beat_t;

    typedef struct {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic                       found;
    } warped_t;

    localparam int NTRI = 64;
    localparam logic [CORNER_W-1:0] CORNER_1 = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_NONE = 2'd3;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_func;
    logic [SLOT_W-1:0]          s_slot;
    logic [CORNER_W-1:0]        s_corner;
    logic signed [COORD_W-1:0]  s_point_x;
    logic signed [COORD_W-1:0]  s_point_y;
    logic signed [COORD_W-1:0]  s_dest_x;
    logic signed [COORD_W-1:0]  s_dest_y;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [COORD_W-1:0]  m_out_x;
    logic signed [COORD_W-1:0]  m_out_y;
    logic                       m_found;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    piecewise_affine_mesh_warp uut (.*);

    // predictor state: affine registers, slot count and the triangle table
    logic signed [31:0] mat_xx, mat_xy, mat_yx, mat_yy, off_x, off_y;
    logic [TC_W-1:0]    tri_count;
    vtx_t               mesh_src [0:3*NTRI-1];
    vtx_t               mesh_dst [0:3*NTRI-1];

    warped_t warped_q[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      stall_left = 0;

    always #1 aclk = ~aclk;

    function automatic wide_t wide(input logic signed [31:0] a);
        wide_t r;
        r = a;
        return r;
    endfunction

    // drop 16 fraction bits, nearest with ties up, saturate to 32 bits
    function automatic logic signed [31:0] round_q16(input wide_t x);
        wide_t r;
        r = (x + 96'sd32768) >>> 16;
        if (r < wide(32'sh80000000)) return 32'sh80000000;
        if (r > wide(32'sh7fffffff)) return 32'sh7fffffff;
        return r[31:0];
    endfunction

    // ratio n/d in 16 fraction bits, ties up
    function automatic wide_t bary_weight(input wide_t n, input wide_t d);
        return ((n <<< 17) + d) / (d <<< 1);
    endfunction

    function automatic int active_slots();
        return (tri_count > NTRI) ? NTRI : int'(tri_count);
    endfunction

    function automatic void load_corner(input beat_t b);
        if (b.corner != CORNER_NONE) begin
            mesh_src[b.slot*3 + b.corner].x = b.px;
            mesh_src[b.slot*3 + b.corner].y = b.py;
            mesh_dst[b.slot*3 + b.corner].x = b.dx;
            mesh_dst[b.slot*3 + b.corner].y = b.dy;
        end
    endfunction

    // affine map, first containing triangle, move to front, barycentric warp
    function automatic warped_t warp_point(input beat_t b);
        warped_t res;
        wide_t   ax, ay, e0x, e0y, e1x, e1y, e2x, e2y, d, vn, wn, u, v, w;
        vtx_t    ss [3];
        vtx_t    dd [3];
        logic signed [31:0] ox, oy;
        int      n;
        bit      hit;
        ox = round_q16(wide(b.px) * wide(mat_xx) + wide(b.py) * wide(mat_xy)
                       + (wide(off_x) <<< 16));
        oy = round_q16(wide(b.px) * wide(mat_yx) + wide(b.py) * wide(mat_yy)
                       + (wide(off_y) <<< 16));
        res.x = ox;
        res.y = oy;
        res.found = 1'b0;
        n = active_slots();
        hit = 0;
        for (int i = 0; i < n && !hit; i++) begin
            ax  = wide(mesh_src[i*3].x);
            ay  = wide(mesh_src[i*3].y);
            e0x = wide(mesh_src[i*3+1].x) - ax;
            e0y = wide(mesh_src[i*3+1].y) - ay;
            e1x = wide(mesh_src[i*3+2].x) - ax;
            e1y = wide(mesh_src[i*3+2].y) - ay;
            e2x = wide(ox) - ax;
            e2y = wide(oy) - ay;
            d   = e0x * e1y - e0y * e1x;
            if (d == 0) continue;
            vn = e2x * e1y - e2y * e1x;
            wn = e0x * e2y - e0y * e2x;
            // clockwise triangle: flip signs so the area is positive
            if (d < 0) begin
                d  = -d;
                vn = -vn;
                wn = -wn;
            end
            if (vn >= 0 && wn >= 0 && vn + wn <= d) begin
                hit = 1;
                v = bary_weight(vn, d);
                w = bary_weight(wn, d);
                u = 96'sd65536 - v - w;
                for (int c = 0; c < 3; c++) begin
                    ss[c] = mesh_src[i*3+c];
                    dd[c] = mesh_dst[i*3+c];
                end
                // move the hit triangle to slot 0
                for (int k = i; k > 0; k--) begin
                    for (int c = 0; c < 3; c++) begin
                        mesh_src[k*3+c] = mesh_src[(k-1)*3+c];
                        mesh_dst[k*3+c] = mesh_dst[(k-1)*3+c];
                    end
                end
                for (int c = 0; c < 3; c++) begin
                    mesh_src[c] = ss[c];
                    mesh_dst[c] = dd[c];
                end
                res.x = round_q16(u * wide(dd[0].x) + v * wide(dd[1].x) + w * wide(dd[2].x));
                res.y = round_q16(u * wide(dd[0].y) + v * wide(dd[1].y) + w * wide(dd[2].y));
                res.found = 1'b1;
            end
        end
        return res;
    endfunction

    // register write, mirrored in the predictor
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_MAT_XX:  mat_xx = val;
            REG_MAT_XY:  mat_xy = val;
            REG_MAT_YX:  mat_yx = val;
            REG_MAT_YY:  mat_yy = val;
            REG_SHIFT_X: off_x = val;
            REG_SHIFT_Y: off_y = val;
            REG_TCOUNT:  tri_count = val[TC_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_affine(input logic [31:0] xx, xy, yx, yy, sx, sy);
        cfg_write(REG_MAT_XX, xx);
        cfg_write(REG_MAT_XY, xy);
        cfg_write(REG_MAT_YX, yx);
        cfg_write(REG_MAT_YY, yy);
        cfg_write(REG_SHIFT_X, sx);
        cfg_write(REG_SHIFT_Y, sy);
    endtask

    // send one beat with random idle before it, predict at acceptance
    task automatic send_beat(input beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_func    <= b.func;
        s_slot    <= b.slot;
        s_corner  <= b.corner;
        s_point_x <= b.px;
        s_point_y <= b.py;
        s_dest_x  <= b.dx;
        s_dest_y  <= b.dy;
        do @(posedge aclk); while (!s_ready);
        if (b.func == FUNC_LOAD) load_corner(b);
        else warped_q = {warped_q, warp_point(b)};
    endtask

    // let the block drain before touching registers
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (warped_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic beat_t load_beat(input int slot, input logic [1:0] corner,
                                        input logic [31:0] sx, sy, dx, dy);
        beat_t b;
        b.func = FUNC_LOAD;
        b.slot = SLOT_W'(slot);
        b.corner = corner;
        b.px = sx;
        b.py = sy;
        b.dx = dx;
        b.dy = dy;
        return b;
    endfunction

    function automatic beat_t point_beat(input logic [31:0] x, y);
        beat_t b;
        b = load_beat($urandom_range(63), CORNER_W'($urandom_range(3)), x, y,
                      $urandom, $urandom);
        b.func = FUNC_POINT;
        return b;
    endfunction

    function automatic logic [31:0] near(input logic [31:0] base, input int span);
        return base + $urandom_range(2*span) - span;
    endfunction

    // point inside (or on) triangle i of the current table
    function automatic beat_t hit_point(input int i);
        longint ax, ay, a, c;
        ax = mesh_src[i*3].x;
        ay = mesh_src[i*3].y;
        a = $urandom_range(16);
        c = $urandom_range(16 - a);
        return point_beat(
            32'(ax + ((longint'(mesh_src[i*3+1].x) - ax) * a
                      + (longint'(mesh_src[i*3+2].x) - ax) * c) / 16),
            32'(ay + ((longint'(mesh_src[i*3+1].y) - ay) * a
                      + (longint'(mesh_src[i*3+2].y) - ay) * c) / 16));
    endfunction

    // one triangle: small and overlapping, clockwise or not, degenerate or huge
    task automatic load_triangle(input int slot);
        int          kind;
        logic [31:0] ax, ay;
        kind = $urandom_range(9);
        ax = near(0, 1 << 14);
        ay = near(0, 1 << 14);
        for (int c = 0; c < 3; c++) begin
            logic [31:0] x, y;
            if (kind == 0) begin
                x = ax + c * 300;
                y = ay + c * 700;
            end else if (kind == 1) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = (c == 0) ? ax : near(ax, 1 << 12);
                y = (c == 0) ? ay : near(ay, 1 << 12);
            end
            send_beat(load_beat(slot, CORNER_W'(c), x, y,
                                ($urandom_range(3) == 0) ? $urandom : near(0, 1 << 16),
                                ($urandom_range(3) == 0) ? $urandom : near(0, 1 << 16)));
        end
    endtask

    function automatic beat_t random_beat();
        int r;
        r = $urandom_range(99);
        if (r < 65 && active_slots() > 0) return hit_point($urandom_range(active_slots() - 1));
        if (r < 72) return point_beat($urandom, $urandom);
        if (r < 80) return point_beat(near(0, 1 << 15), near(0, 1 << 15));
        if (r < 95) return load_beat($urandom_range(63), CORNER_W'($urandom_range(2)),
                                     near(0, 1 << 14), near(0, 1 << 14), $urandom, $urandom);
        return load_beat($urandom_range(63), CORNER_NONE, $urandom, $urandom,
                         $urandom, $urandom);
    endfunction

    // result channel: random stall, or a long counted hold-off on request
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (warped_q.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h found=%b",
                         $realtime, m_out_x, m_out_y, m_found);
                errors++;
            end else begin
                warped_t e;
                e = warped_q.pop_front();
                if (m_out_x !== e.x) begin
                    $display("%0t: out_x expected %h actual %h", $realtime, e.x, m_out_x);
                    errors++;
                end
                if (m_out_y !== e.y) begin
                    $display("%0t: out_y expected %h actual %h", $realtime, e.y, m_out_y);
                    errors++;
                end
                if (m_found !== e.found) begin
                    $display("%0t: found expected %b actual %b", $realtime, e.found, m_found);
                    errors++;
                end
            end
        end
    end

    // fill every slot so no search ever touches an unwritten corner
    task automatic test_fill_mesh();
        for (int s = 0; s < NTRI; s++) load_triangle(s);
    endtask

    // empty table, degenerate skip, edges, vertices, clockwise, corner 3
    task automatic test_directed();
        send_beat(point_beat(32'h80000000, 32'h7fffffff));
        send_beat(point_beat(32'h7fffffff, 32'h80000000));
        wait_idle();
        cfg_write(REG_TCOUNT, 64);
        send_beat(load_beat(0, CORNER_0, 0, 0, 0, 0));
        send_beat(load_beat(0, CORNER_1, 100, 100, 5000, 5000));
        send_beat(load_beat(0, CORNER_2, 200, 200, 9000, 9000));
        send_beat(load_beat(1, CORNER_0, 0, 0, 32'h7fffffff, 32'h80000000));
        send_beat(load_beat(1, CORNER_1, 0, 4096, 32'h80000000, 32'h7fffffff));
        send_beat(load_beat(1, CORNER_2, 4096, 0, 1000, -1000));
        send_beat(load_beat(1, CORNER_NONE, 7, 7, 7, 7));
        send_beat(point_beat(50, 50));
        send_beat(point_beat(0, 0));
        send_beat(point_beat(2048, 0));
        send_beat(point_beat(2048, 2048));
        send_beat(point_beat(1365, 1365));
        send_beat(point_beat(0, 4096));
        send_beat(point_beat(2049, 2048));
        send_beat(point_beat(-1, 0));
        send_beat(point_beat(0, 32'h80000000));
        send_beat(point_beat(32'hffffffff, 32'hffffffff));
        wait_idle();
    endtask

    // affine extremes and slot counts, including saturated counts
    task automatic test_affine_settings();
        logic [6:0] counts [6] = '{0, 1, 127, 65, 64, 33};
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: set_affine(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h80000000);
                1: set_affine(32'h80000000, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
                2: set_affine(32'h00008000, 32'hffff8000, 32'h00018000, 32'h00010000, 1, -1);
                default: set_affine($urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom);
            endcase
            cfg_write(REG_TCOUNT, counts[k]);
            for (int j = 0; j < 12; j++) begin
                if (j < 4) send_beat(point_beat($urandom, $urandom));
                else if (j < 8) send_beat(point_beat(near(0, 1 << 15), near(0, 1 << 15)));
                else send_beat(random_beat());
            end
            wait_idle();
        end
        set_affine(32'h00010000, 0, 0, 32'h00010000, 0, 0);
    endtask

    task automatic test_random(input int beats, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        cfg_write(REG_TCOUNT, $urandom_range(1, 64));
        for (int j = 0; j < beats; j++) begin
            send_beat(random_beat());
            if (j == beats / 2) begin
                wait_idle();
                cfg_write(REG_TCOUNT, ($urandom_range(3) == 0) ? 64 : $urandom_range(1, 16));
            end
        end
        wait_idle();
    endtask

    // long receiver hold-off while beats keep coming, then a full drain
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_write(REG_TCOUNT, 4);
        stall_left = 800;
        for (int j = 0; j < 40; j++) send_beat(random_beat());
        wait_idle();
        for (int j = 0; j < 10; j++) send_beat(hit_point($urandom_range(3)));
        wait_idle();
    endtask

    initial begin
        #40_000_000;
        $display("piecewise_affine_mesh_warp_test: errors");
        $finish;
    end

    initial begin
        aclk = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_func <= FUNC_LOAD;
        s_slot <= '0;
        s_corner <= CORNER_0;
        s_point_x <= '0;
        s_point_y <= '0;
        s_dest_x <= '0;
        s_dest_y <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MAT_XX;
        cfg_data <= '0;
        mat_xx = 32'h00010000;
        mat_xy = 0;
        mat_yx = 0;
        mat_yy = 32'h00010000;
        off_x = 0;
        off_y = 0;
        tri_count = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_fill_mesh();
        wait_idle();
        test_directed();
        test_directed();
        test_affine_settings();
        test_random(50, 0, 0);
        test_random(50, 59, 0);
        test_random(50, 0, 59);
        test_random(50, 26, 26);
        test_backpressure();
        repeat (50) @(posedge aclk);
        if (errors == 0 && warped_q.size() == 0) begin
            $display("piecewise_affine_mesh_warp_test: clean");
        end else begin
            $display("piecewise_affine_mesh_warp_test: errors");
        end
        $finish;
    end

endmodule
